/* hw/rtl/lrt_pkg.sv */
`default_nettype none

package lrt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 3;
    localparam int ACTION_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int REMOVED_W = 6;
    localparam int MLEN_W    = $clog2(ADDR_W + 1);

    localparam logic [ACTION_W-1:0] ACT_LOOKUP     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD        = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEACTIVATE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ACTIVATE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // One stored route. The mask length is computed once when the route is added.
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
        logic              active;
        logic [MLEN_W-1:0] mlen;
    } route_entry_t;

    typedef struct packed {
        logic clear;
        logic step;
    } sel_ctl_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] hop_addr;
        logic [PORT_W-1:0] port;
    } sel_result_t;

    function automatic logic [MLEN_W-1:0] mask_len(input logic [ADDR_W-1:0] mask);
        logic [MLEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < ADDR_W; i++)
        begin
            n = n + MLEN_W'(mask[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lrt_if.sv */
`default_nettype none

interface lrt_req_if;
    import lrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   prefix_mask;
    logic [ADDR_W-1:0]   gateway;
    logic [PORT_W-1:0]   port;

    modport source (output valid, action, address, prefix_mask, gateway, port,
                    input ready);
    modport sink (input valid, action, address, prefix_mask, gateway, port,
                  output ready);
endinterface

interface lrt_rsp_if;
    import lrt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    hop_addr;
    logic [PORT_W-1:0]    out_port;
    logic [REMOVED_W-1:0] removed_count;

    modport source (output valid, status, hop_addr, out_port, removed_count,
                    input ready);
    modport sink (input valid, status, hop_addr, out_port, removed_count,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/lpm_route_table_unit.sv */
`default_nettype none

// IPv4 longest-prefix-match route table with up to TABLE_DEPTH routes, kept as a
// compacted list in insertion order in a single-port-read, single-port-write RAM.
// Every request transaction produces exactly one response transaction. Lookup,
// delete, deactivate and activate walk the stored routes one per cycle through the
// RAM read port; add and the unused action codes skip the walk. The request side is
// ready only while the sequencer is idle. The response is held in an output register
// until taken, and a finished operation waits for that register to empty before
// the block goes idle again. A lookup miss returns status 1 with zero next hop and
// port; an add to a full table returns status 2 and leaves the table unchanged.
module lpm_route_table_unit (
    input  logic       clk,
    input  logic       rst_n,
    lrt_req_if.sink    req,
    lrt_rsp_if.source  rsp
);
    import lrt_pkg::*;

    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] ST_WALK = 2'd1;
    localparam logic [STATE_W-1:0] ST_FIN  = 2'd2;

    logic [STATE_W-1:0]   state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic                 pv_reg, pv_next;
    logic [CNT_W-1:0]     wptr_reg, wptr_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;

    logic [ACTION_W-1:0]  action_reg, action_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [ADDR_W-1:0]    mask_reg, mask_next;
    logic [PORT_W-1:0]    port_reg, port_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [ADDR_W-1:0]    rsp_hop_reg, rsp_hop_next;
    logic [PORT_W-1:0]    rsp_port_reg, rsp_port_next;
    logic [REMOVED_W-1:0] rsp_removed_reg, rsp_removed_next;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    route_entry_t         wdata;
    logic [IDX_W-1:0]     raddr;
    route_entry_t         rdata;

    sel_ctl_t             sel_ctl;
    sel_result_t          sel_res;

    logic                 del_match;
    logic                 is_lookup;

    lrt_route_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    lrt_select_unit u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sel_ctl),
        .entry   (rdata),
        .address (addr_reg),
        .result  (sel_res)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign raddr     = idx_reg[IDX_W-1:0];
    assign del_match = (rdata.prefix == addr_reg) && (rdata.mask == mask_reg);
    assign is_lookup = (action_reg == ACT_LOOKUP);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        pidx_next        = pidx_reg;
        pv_next          = 1'b0;
        wptr_next        = wptr_reg;
        removed_next     = removed_reg;
        action_next      = action_reg;
        addr_next        = addr_reg;
        mask_next        = mask_reg;
        port_next        = port_reg;
        status_next      = status_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_hop_next     = rsp_hop_reg;
        rsp_port_next    = rsp_port_reg;
        rsp_removed_next = rsp_removed_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;

        we            = 1'b0;
        waddr         = '0;
        wdata         = rdata;
        sel_ctl.clear = 1'b0;
        sel_ctl.step  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    action_next   = req.action;
                    addr_next     = req.address;
                    mask_next     = req.prefix_mask;
                    port_next     = req.port;
                    status_next   = ST_OK;
                    idx_next      = '0;
                    wptr_next     = '0;
                    removed_next  = '0;
                    sel_ctl.clear = 1'b1;
                    unique case (req.action) inside
                        ACT_ADD:
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we            = 1'b1;
                                waddr         = count_reg[IDX_W-1:0];
                                wdata.prefix  = req.address;
                                wdata.mask    = req.prefix_mask;
                                wdata.gateway = req.gateway;
                                wdata.port    = req.port;
                                wdata.active  = 1'b1;
                                wdata.mlen    = mask_len(req.prefix_mask);
                                count_next    = count_reg + 1'b1;
                            end
                            state_next = ST_FIN;
                        end
                        ACT_LOOKUP, ACT_DELETE, ACT_DEACTIVATE, ACT_ACTIVATE:
                        begin
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // Issue the read of the next stored route while the route read
                // in the previous cycle is processed.
                if (idx_reg < count_reg)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pidx_next = idx_reg[IDX_W-1:0];
                    pv_next   = 1'b1;
                end

                if (pv_reg)
                begin
                    case (action_reg)
                        ACT_LOOKUP:
                        begin
                            sel_ctl.step = 1'b1;
                        end
                        ACT_DELETE:
                        begin
                            if (del_match)
                            begin
                                removed_next = removed_reg + 1'b1;
                            end
                            else
                            begin
                                we        = 1'b1;
                                waddr     = wptr_reg[IDX_W-1:0];
                                wptr_next = wptr_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (rdata.port == port_reg)
                            begin
                                we           = 1'b1;
                                waddr        = pidx_reg;
                                wdata.active = (action_reg == ACT_ACTIVATE);
                            end
                        end
                    endcase
                end
                else if (idx_reg == count_reg)
                begin
                    if (action_reg == ACT_DELETE)
                    begin
                        count_next = wptr_reg;
                    end
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_removed_next = REMOVED_W'(removed_reg);
                    if (is_lookup)
                    begin
                        rsp_status_next = sel_res.found ? ST_OK : ST_MISS;
                        rsp_hop_next    = sel_res.found ? sel_res.hop_addr : '0;
                        rsp_port_next   = sel_res.found ? sel_res.port : '0;
                    end
                    else
                    begin
                        rsp_status_next = status_reg;
                        rsp_hop_next    = '0;
                        rsp_port_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            wptr_reg      <= '0;
            removed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pv_reg        <= pv_next;
            wptr_reg      <= wptr_next;
            removed_reg   <= removed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg        <= pidx_next;
        action_reg      <= action_next;
        addr_reg        <= addr_next;
        mask_reg        <= mask_next;
        port_reg        <= port_next;
        status_reg      <= status_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_hop_reg     <= rsp_hop_next;
        rsp_port_reg    <= rsp_port_next;
        rsp_removed_reg <= rsp_removed_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.hop_addr      = rsp_hop_reg;
    assign rsp.out_port      = rsp_port_reg;
    assign rsp.removed_count = rsp_removed_reg;

    // The route count never exceeds the table capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("route count exceeds table depth");

    // The RAM is written only by an accepted add or while a walk processes a route.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ((state_reg == ST_WALK) && pv_reg) ||
               ((state_reg == ST_IDLE) && req.valid && (req.action == ACT_ADD)))
        else $error("route RAM written outside an add or a walk");

    // At the end of a delete walk, kept plus removed routes equal the routes processed.
    a_delete_tally: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && (action_reg == ACT_DELETE) && !pv_reg &&
         (idx_reg == count_reg)) |-> ((wptr_reg + removed_reg) == count_reg))
        else $error("delete walk lost track of routes");

    // A new response only appears after the sequencer finished an operation.
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !$past(rsp_valid_reg)) |-> $past(state_reg == ST_FIN))
        else $error("response raised outside the finish state");

endmodule

`default_nettype wire

/* hw/rtl/lrt_route_ram.sv */
`default_nettype none

module lrt_route_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [lrt_pkg::IDX_W-1:0] waddr,
    input  lrt_pkg::route_entry_t     wdata,
    input  logic [lrt_pkg::IDX_W-1:0] raddr,
    output lrt_pkg::route_entry_t     rdata
);
    import lrt_pkg::*;

    route_entry_t route_mem [TABLE_DEPTH];
    route_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            route_mem[waddr] <= wdata;
        end
        rdata_reg <= route_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/lrt_select_unit.sv */
`default_nettype none

module lrt_select_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lrt_pkg::sel_ctl_t          ctl,
    input  lrt_pkg::route_entry_t      entry,
    input  logic [lrt_pkg::ADDR_W-1:0] address,
    output lrt_pkg::sel_result_t       result
);
    import lrt_pkg::*;

    localparam int KEY_W = MLEN_W + 2 * ADDR_W;

    logic              found_reg;
    logic              found_next;
    logic [KEY_W-1:0]  best_key_reg;
    logic [KEY_W-1:0]  best_key_next;
    logic [ADDR_W-1:0] best_gw_reg;
    logic [ADDR_W-1:0] best_gw_next;
    logic [PORT_W-1:0] best_port_reg;
    logic [PORT_W-1:0] best_port_next;

    logic              hit;
    logic [KEY_W-1:0]  cand_key;
    logic              take;

    // The ranking key orders by mask length, then mask value, then prefix.
    // A strict compare keeps the earliest route on a full tie.
    assign hit      = entry.active && (((entry.prefix ^ address) & entry.mask) == '0);
    assign cand_key = {entry.mlen, entry.mask, entry.prefix};
    assign take     = ctl.step && hit && (!found_reg || (cand_key > best_key_reg));

    always_comb
    begin
        found_next     = found_reg;
        best_key_next  = best_key_reg;
        best_gw_next   = best_gw_reg;
        best_port_next = best_port_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next     = 1'b1;
            best_key_next  = cand_key;
            best_gw_next   = entry.gateway;
            best_port_next = entry.port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_key_reg  <= best_key_next;
        best_gw_reg   <= best_gw_next;
        best_port_reg <= best_port_next;
    end

    assign result.found    = found_reg;
    assign result.hop_addr = (best_gw_reg == '0) ? address : best_gw_reg;
    assign result.port     = best_port_reg;

endmodule

`default_nettype wire
